FILE: design/jse_pkg.sv
// Shared types, codes and helpers for the JSON string escaper.
`default_nettype none
package jse_pkg;

  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int IDX_W      = 3;

  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_UNI   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] val;
    logic       done;
  } cmd_t;

  localparam logic [IDX_W-1:0] LEN_PLAIN = 3'd1;
  localparam logic [IDX_W-1:0] LEN_SHORT = 3'd2;
  localparam logic [IDX_W-1:0] LEN_UNI   = 3'd6;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'b0, d};
    end else begin
      r = 8'h57 + {4'b0, d};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/jse_front.sv
// Front end: accepts input transactions and classifies them into escape commands.
`default_nettype none
module jse_front (
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_action,
  input  wire logic [7:0]       in_data_byte,
  output logic                  push,
  output jse_pkg::cmd_t         push_cmd,
  input  wire logic             q_ready
);

  always_comb begin
    push_cmd.kind = jse_pkg::KIND_PLAIN;
    push_cmd.val  = jse_pkg::CH_QUOTE;
    push_cmd.done = 1'b0;
    unique case (in_action)
      jse_pkg::ACT_BEGIN: ;
      jse_pkg::ACT_END: push_cmd.done = 1'b1;
      jse_pkg::ACT_DATA: begin
        push_cmd.kind = jse_pkg::KIND_SHORT;
        unique case (in_data_byte)
          jse_pkg::CH_QUOTE:  push_cmd.val = jse_pkg::CH_QUOTE;
          jse_pkg::CH_BSLASH: push_cmd.val = jse_pkg::CH_BSLASH;
          8'h08:              push_cmd.val = jse_pkg::CH_LOWER_B;
          8'h0C:              push_cmd.val = jse_pkg::CH_LOWER_F;
          8'h0A:              push_cmd.val = jse_pkg::CH_LOWER_N;
          8'h0D:              push_cmd.val = jse_pkg::CH_LOWER_R;
          8'h09:              push_cmd.val = jse_pkg::CH_LOWER_T;
          default: begin
            push_cmd.val = in_data_byte;
            if (in_data_byte < jse_pkg::CTRL_LIMIT) begin
              push_cmd.kind = jse_pkg::KIND_UNI;
            end else begin
              push_cmd.kind = jse_pkg::KIND_PLAIN;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready && (in_action != jse_pkg::ACT_NONE);

endmodule
`default_nettype wire

FILE: design/jse_fifo.sv
// Short command queue between the front end and the emitter.
`default_nettype none
module jse_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire jse_pkg::cmd_t push_cmd,
  output logic               q_ready,
  input  wire logic          pop,
  output logic               q_valid,
  output jse_pkg::cmd_t      q_cmd
);

  jse_pkg::cmd_t                 mem_r [jse_pkg::FIFO_DEPTH];
  logic [jse_pkg::PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [jse_pkg::PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [jse_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  localparam logic [jse_pkg::CNT_W-1:0] DEPTH_C = jse_pkg::CNT_W'(jse_pkg::FIFO_DEPTH);
  localparam logic [jse_pkg::PTR_W-1:0] LAST_C  = jse_pkg::PTR_W'(jse_pkg::FIFO_DEPTH - 1);

  assign q_ready = (cnt_r != DEPTH_C);
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |=> (cnt_r <= 1)) else $error("queue count jumped from empty");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r)) else $error("empty queue with pointer gap");

endmodule
`default_nettype wire

FILE: design/jse_back.sv
// Emitter: steps through each queued command and drives the output register.
`default_nettype none
module jse_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire jse_pkg::cmd_t q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last_of_run,
  output logic               out_string_done
);

  logic [jse_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                byte_r, byte_nxt;
  logic                      last_r, done_r;
  logic [jse_pkg::IDX_W-1:0] len;
  logic                      load, step, last;

  always_comb begin
    case (q_cmd.kind)
      jse_pkg::KIND_SHORT: len = jse_pkg::LEN_SHORT;
      jse_pkg::KIND_UNI:   len = jse_pkg::LEN_UNI;
      default:             len = jse_pkg::LEN_PLAIN;
    endcase
  end

  assign load = !out_valid_r || out_ready;
  assign step = load && q_valid;
  assign last = (idx_r == len - 1'b1);
  assign pop  = step && last;

  always_comb begin
    byte_nxt = q_cmd.val;
    case (q_cmd.kind)
      jse_pkg::KIND_SHORT: begin
        byte_nxt = (idx_r == '0) ? jse_pkg::CH_BSLASH : q_cmd.val;
      end
      jse_pkg::KIND_UNI: begin
        case (idx_r)
          3'd0:    byte_nxt = jse_pkg::CH_BSLASH;
          3'd1:    byte_nxt = jse_pkg::CH_LOWER_U;
          3'd4:    byte_nxt = jse_pkg::hex_digit(q_cmd.val[7:4]);
          3'd5:    byte_nxt = jse_pkg::hex_digit(q_cmd.val[3:0]);
          default: byte_nxt = jse_pkg::CH_ZERO;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = load ? q_valid : out_valid_r;
    idx_nxt       = idx_r;
    if (step) begin
      idx_nxt = last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byte_r <= byte_nxt;
      last_r <= last;
      done_r <= last && q_cmd.done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = last_r;
  assign out_string_done = done_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < jse_pkg::LEN_UNI) else $error("escape index out of range");
  a_idx_holds_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> q_valid) else $error("escape in progress with empty queue");
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (last_r && byte_r == jse_pkg::CH_QUOTE))
    else $error("string end not on closing quote");

endmodule
`default_nettype wire

FILE: design/json_string_escaper.sv
// JSON string escaper top level: front end, command queue and emitter.
//
// Input channel (in_valid/in_ready, in_action, in_data_byte): one transaction
// per begin, data byte or end. Unused action code 3 is taken and dropped.
// Output channel (out_valid/out_ready): one escaped text byte per transaction,
// with out_last_of_run on the final byte of each input and out_string_done on
// the closing quote.
// The command of each input transaction is first written into the command
// queue, and the emitter then loads its first output byte into the output
// register.
// Throughput: one input per cycle for plain bytes and quotes unless output
// stalls; two-byte and \u00XX escapes are paced by the emitter, which makes
// one output byte per cycle while out_ready is high. A two-entry command queue
// lets the front end keep accepting while the emitter works or waits.
// Reset clears the queue and the output stage; no string state is kept.
// When the receiver stalls, the output byte holds, the emitter stops, and
// input is refused once the queue fills.
`default_nettype none
module json_string_escaper (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_action,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run,
  output logic            out_string_done
);

  logic          push, q_ready, q_valid, pop;
  jse_pkg::cmd_t push_cmd, q_cmd;

  jse_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .push         (push),
    .push_cmd     (push_cmd),
    .q_ready      (q_ready)
  );

  jse_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  jse_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_string_done (out_string_done)
  );

endmodule
`default_nettype wire
